// File: rtl/kpsd_pkg.sv
// Shared types, constants and the waveform lookup for the keypad scan/debounce controller.
package kpsd_pkg;

	localparam int unsigned ROW_W    = 4;
	localparam int unsigned COL_W    = 2;
	localparam int unsigned SNAP_W   = 12;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned FREQ_W   = 12;
	localparam int unsigned MULT_W   = 3;
	localparam int unsigned KEY_W    = 4;
	localparam int unsigned WAVE_W   = 4;
	localparam int unsigned CFG_IX_W = 3;
	localparam int unsigned CFG_D_W  = 12;

	// Configuration register indexes
	localparam logic [CFG_IX_W-1:0] REG_SETTLE   = 3'd0;
	localparam logic [CFG_IX_W-1:0] REG_FREQ_MIN = 3'd1;
	localparam logic [CFG_IX_W-1:0] REG_FREQ_MAX = 3'd2;
	localparam logic [CFG_IX_W-1:0] REG_MULT_MIN = 3'd3;
	localparam logic [CFG_IX_W-1:0] REG_MULT_MAX = 3'd4;

	// Configuration reset values
	localparam logic [CNT_W-1:0]  SETTLE_RST   = 8'd50;
	localparam logic [FREQ_W-1:0] FREQ_MIN_RST = 12'd100;
	localparam logic [FREQ_W-1:0] FREQ_MAX_RST = 12'd2000;
	localparam logic [MULT_W-1:0] MULT_MIN_RST = 3'd1;
	localparam logic [MULT_W-1:0] MULT_MAX_RST = 3'd5;

	// Setting reset values
	localparam logic [FREQ_W-1:0] FREQ_RST = 12'd161;
	localparam logic [MULT_W-1:0] MULT_RST = 3'd1;
	localparam logic [KEY_W-1:0]  KEY_SINE = 4'd11;

	// Key codes with a special meaning
	localparam logic [KEY_W-1:0] KEY_UP   = 4'd0;
	localparam logic [KEY_W-1:0] KEY_FUNC = 4'd4;
	localparam logic [KEY_W-1:0] KEY_DOWN = 4'd8;

	// Last column of the scan
	localparam logic [COL_W-1:0] COL_LAST = 2'd2;

	// Result of one scan tick
	typedef struct packed {
		logic [COL_W-1:0]  column_drive;
		logic              key_decoded;
		logic [KEY_W-1:0]  key_index;
		logic              regenerate;
		logic [FREQ_W-1:0] frequency;
		logic [MULT_W-1:0] multiplier;
		logic [WAVE_W-1:0] waveform_code;
		logic              function_mode;
	} res_t;

	// Map a selected key to its waveform number; unused positions read as sine
	function automatic logic [WAVE_W-1:0] wave_lookup(input logic [KEY_W-1:0] key);
		logic [WAVE_W-1:0] code;
		case (key)
			4'd1:    code = 4'd9;
			4'd2:    code = 4'd6;
			4'd3:    code = 4'd3;
			4'd4:    code = 4'd10;
			4'd5:    code = 4'd8;
			4'd6:    code = 4'd5;
			4'd7:    code = 4'd2;
			4'd8:    code = 4'd10;
			4'd9:    code = 4'd7;
			4'd10:   code = 4'd4;
			default: code = 4'd1;
		endcase
		return code;
	endfunction

endpackage

// File: rtl/kpsd_core.sv
// Scan, debounce and key-action logic with its state and configuration registers.
module kpsd_core import kpsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [CFG_D_W-1:0]  cfg_data,
	input  logic                step,
	input  logic [ROW_W-1:0]    row_bits,
	output res_t                res
);

	logic [CNT_W-1:0]  settle_q;
	logic [FREQ_W-1:0] freq_min_q, freq_max_q;
	logic [MULT_W-1:0] mult_min_q, mult_max_q;

	logic [COL_W-1:0]  col_q, col_nxt;
	logic [SNAP_W-1:0] snap_q, snap_nxt;
	logic [CNT_W-1:0]  cnt_q, cnt_inc, cnt_nxt;
	logic [FREQ_W-1:0] freq_q, freq_nxt;
	logic [MULT_W-1:0] mult_q, mult_nxt;
	logic [KEY_W-1:0]  sel_q, sel_nxt;
	logic              func_q, func_nxt;

	logic              stable;
	logic              decoded;
	logic              regen;
	logic [KEY_W-1:0]  key;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q   <= SETTLE_RST;
			freq_min_q <= FREQ_MIN_RST;
			freq_max_q <= FREQ_MAX_RST;
			mult_min_q <= MULT_MIN_RST;
			mult_max_q <= MULT_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE:   settle_q   <= cfg_data[CNT_W-1:0];
				REG_FREQ_MIN: freq_min_q <= cfg_data[FREQ_W-1:0];
				REG_FREQ_MAX: freq_max_q <= cfg_data[FREQ_W-1:0];
				REG_MULT_MIN: mult_min_q <= cfg_data[MULT_W-1:0];
				REG_MULT_MAX: mult_max_q <= cfg_data[MULT_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the column and merge the sensed rows into the snapshot
	always_comb begin
		col_nxt  = (col_q >= COL_LAST) ? '0 : col_q + 2'd1;
		snap_nxt = snap_q;
		case (col_nxt)
			2'd0:    snap_nxt[3:0]  = row_bits;
			2'd1:    snap_nxt[7:4]  = row_bits;
			default: snap_nxt[11:8] = row_bits;
		endcase
		cnt_inc = cnt_q + 8'd1;
		stable  = (cnt_inc > settle_q) && (snap_nxt == snap_q);
		cnt_nxt = stable ? '0 : cnt_inc;
		decoded = stable && (snap_nxt != '0);
	end

	// Find the lowest pressed key
	always_comb begin
		key = KEY_SINE;
		for (int i = SNAP_W - 2; i >= 0; i--) begin
			if (snap_nxt[i]) key = KEY_W'(i);
		end
	end

	// Apply the key action to the settings
	always_comb begin
		freq_nxt = freq_q;
		mult_nxt = mult_q;
		sel_nxt  = sel_q;
		func_nxt = func_q;
		regen    = 1'b0;
		if (decoded) begin
			if (key == KEY_UP || key == KEY_DOWN) begin
				if (!func_q) begin
					if (key == KEY_UP && freq_q < freq_max_q) freq_nxt = freq_q + 12'd1;
					if (key == KEY_DOWN && freq_q > freq_min_q) freq_nxt = freq_q - 12'd1;
				end else begin
					if (key == KEY_UP && mult_q < mult_max_q) mult_nxt = mult_q + 3'd1;
					if (key == KEY_DOWN && mult_q > mult_min_q) mult_nxt = mult_q - 3'd1;
				end
			end else if (key != KEY_FUNC) begin
				sel_nxt = key;
			end
			if (key == KEY_FUNC) begin
				func_nxt = ~func_q;
			end else begin
				regen = 1'b1;
			end
		end
	end

	// Hold the scan state, advance it on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			snap_q <= '0;
			cnt_q  <= '0;
			freq_q <= FREQ_RST;
			mult_q <= MULT_RST;
			sel_q  <= KEY_SINE;
			func_q <= 1'b0;
		end else if (step) begin
			col_q  <= col_nxt;
			snap_q <= snap_nxt;
			cnt_q  <= cnt_nxt;
			freq_q <= freq_nxt;
			mult_q <= mult_nxt;
			sel_q  <= sel_nxt;
			func_q <= func_nxt;
		end
	end

	// Assemble the result of this tick
	always_comb begin
		res.column_drive  = col_nxt;
		res.key_decoded   = decoded;
		res.key_index     = decoded ? key : '0;
		res.regenerate    = regen;
		res.frequency     = freq_nxt;
		res.multiplier    = mult_nxt;
		res.waveform_code = wave_lookup(sel_nxt);
		res.function_mode = func_nxt;
	end

endmodule

// File: rtl/kpsd_skid.sv
// Two-entry output register with skid stage for result transactions.
module kpsd_skid import kpsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  res_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output res_t pop_data
);

	logic out_valid_q, skid_valid_q;
	res_t out_data_q, skid_data_q;

	assign push_ready = !skid_valid_q;
	assign pop_valid  = out_valid_q;
	assign pop_data   = out_data_q;

	// Track which entries hold a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push_valid;
			end
		end else if (push_valid && push_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Move payload: refill output from skid, or park in skid on a stall
	always_ff @(posedge clk) begin
		if (pop_ready || !out_valid_q) begin
			out_data_q <= skid_valid_q ? skid_data_q : push_data;
		end else if (push_valid && push_ready) begin
			skid_data_q <= push_data;
		end
	end

endmodule

// File: rtl/keypad_scan_debounce_controller.sv
// Top level of the keypad scan and debounce controller.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    row_bits
//   out      source     out_valid / out_ready  column_drive .. function_mode
//   cfg      sink       cfg_we                 cfg_index, cfg_data
//
// One scan tick per transaction, one transaction per cycle sustained while out_ready stays high.
// The result of a taken input is registered into the output register and appears from there.
// A skid entry behind the output register takes one more transaction during a stall,
// then in_ready drops until the output register drains.
// Reset clears the scan state and loads the default settings and limits.
module keypad_scan_debounce_controller import kpsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IX_W-1:0] cfg_index,
	input  logic [CFG_D_W-1:0]  cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ROW_W-1:0]    row_bits,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [COL_W-1:0]    column_drive,
	output logic                key_decoded,
	output logic [KEY_W-1:0]    key_index,
	output logic                regenerate,
	output logic [FREQ_W-1:0]   frequency,
	output logic [MULT_W-1:0]   multiplier,
	output logic [WAVE_W-1:0]   waveform_code,
	output logic                function_mode
);

	res_t res, res_out;
	logic step;

	assign step = in_valid && in_ready;

	kpsd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (step),
		.row_bits  (row_bits),
		.res       (res)
	);

	kpsd_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (res),
		.pop_valid  (out_valid),
		.pop_ready  (out_ready),
		.pop_data   (res_out)
	);

	assign column_drive  = res_out.column_drive;
	assign key_decoded   = res_out.key_decoded;
	assign key_index     = res_out.key_index;
	assign regenerate    = res_out.regenerate;
	assign frequency     = res_out.frequency;
	assign multiplier    = res_out.multiplier;
	assign waveform_code = res_out.waveform_code;
	assign function_mode = res_out.function_mode;

endmodule
